// ===== design/lcdled_pkg.sv =====
// shared constants, types and text helpers for the line command decoder
// no dependencies; used by lcdled_line, lcdled_reply and line_command_decoder_led
package lcdled_pkg;

  localparam int LINE_DEPTH_DEF = 6;

  localparam int BYTE_W      = 8;
  localparam int LAMP_W      = 3;
  localparam int CODE_W      = 3;
  localparam int REPLY_MAX   = 11;
  localparam int REPLY_IDX_W = 4;

  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

  // command words, first character in the top byte
  localparam logic [8*4-1:0] WORD_LEFT   = "LEFT";
  localparam logic [8*6-1:0] WORD_MIDDLE = "MIDDLE";
  localparam logic [8*5-1:0] WORD_RIGHT  = "RIGHT";
  localparam logic [8*3-1:0] WORD_OFF    = "OFF";

  // reply codes
  localparam logic [CODE_W-1:0] RPL_ERR    = 3'd0;
  localparam logic [CODE_W-1:0] RPL_LEFT   = 3'd1;
  localparam logic [CODE_W-1:0] RPL_MIDDLE = 3'd2;
  localparam logic [CODE_W-1:0] RPL_RIGHT  = 3'd3;
  localparam logic [CODE_W-1:0] RPL_OFF    = 3'd4;

  localparam logic [LAMP_W-1:0] LAMP_NONE   = 3'b000;
  localparam logic [LAMP_W-1:0] LAMP_LEFT   = 3'b001;
  localparam logic [LAMP_W-1:0] LAMP_MIDDLE = 3'b010;
  localparam logic [LAMP_W-1:0] LAMP_RIGHT  = 3'b100;

  // reply texts padded with zeros to the longest reply, first byte on top
  localparam logic [8*REPLY_MAX-1:0] TXT_ERR    = {"ERR", CH_CR, CH_LF, 48'h0};
  localparam logic [8*REPLY_MAX-1:0] TXT_LEFT   = {"OK LEFT", CH_CR, CH_LF, 16'h0};
  localparam logic [8*REPLY_MAX-1:0] TXT_MIDDLE = {"OK MIDDLE", CH_CR, CH_LF};
  localparam logic [8*REPLY_MAX-1:0] TXT_RIGHT  = {"OK RIGHT", CH_CR, CH_LF, 8'h0};
  localparam logic [8*REPLY_MAX-1:0] TXT_OFF    = {"OK OFF", CH_CR, CH_LF, 24'h0};

  typedef struct packed {
    logic                  start;
    logic [CODE_W-1:0]     code;
    logic [LAMP_W-1:0]     lamp;
  } lcdled_req_t;

  function automatic logic [REPLY_IDX_W-1:0] reply_len(input logic [CODE_W-1:0] code);
    logic [REPLY_IDX_W-1:0] len;
    case (code)
      RPL_LEFT:   len = 4'd9;
      RPL_MIDDLE: len = 4'd11;
      RPL_RIGHT:  len = 4'd10;
      RPL_OFF:    len = 4'd8;
      default:    len = 4'd5;
    endcase
    return len;
  endfunction

  function automatic logic [BYTE_W-1:0] reply_char(input logic [CODE_W-1:0]      code,
                                                   input logic [REPLY_IDX_W-1:0] idx);
    logic [8*REPLY_MAX-1:0] txt;
    logic [BYTE_W-1:0]      ch;
    case (code)
      RPL_LEFT:   txt = TXT_LEFT;
      RPL_MIDDLE: txt = TXT_MIDDLE;
      RPL_RIGHT:  txt = TXT_RIGHT;
      RPL_OFF:    txt = TXT_OFF;
      default:    txt = TXT_ERR;
    endcase
    ch = '0;
    for (int k = 0; k < REPLY_MAX; k++) begin
      if (idx == REPLY_IDX_W'(k)) begin
        ch = txt[8*(REPLY_MAX-1-k) +: 8];
      end
    end
    return ch;
  endfunction

endpackage

// ===== design/line_command_decoder_led.sv =====
// top level of the text line command decoder driving three lamps
// depends on lcdled_pkg, lcdled_line and lcdled_reply
//
//   port group   dir  carries
//   in_*         in   received text bytes, one per transfer
//   out_*        out  reply text bytes with lamp state, tlast on the final LF
//
// ordinary bytes and empty line ends are taken one per cycle while no reply is running
// any other line end starts a reply of 5 to 11 bytes, one per cycle while out_tready
// is high; input is held off until the reply sequencer has loaded the final byte
// while out_tready is low the result register holds one byte and the sequencer waits
// rst_n is synchronous, active low; it clears length, overflow, lamps and the sequencer
module line_command_decoder_led #(
  parameter int LINE_DEPTH = lcdled_pkg::LINE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] reply_byte, [10:8] lamp_bits, [15:11] zero
  output logic        out_tlast
);
  import lcdled_pkg::*;

  lcdled_req_t       req;
  logic              seq_idle;
  logic              in_take;
  logic [BYTE_W-1:0] rep_byte;
  logic [LAMP_W-1:0] rep_lamp;

  assign in_tready = seq_idle;
  assign in_take   = in_tvalid && in_tready;

  lcdled_line #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (in_take),
    .in_byte (in_tdata),
    .req     (req)
  );

  lcdled_reply u_reply (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .idle      (seq_idle),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (rep_byte),
    .out_last  (out_tlast),
    .out_lamp  (rep_lamp)
  );

  assign out_tdata = {5'b0, rep_lamp, rep_byte};

endmodule

// ===== design/lcdled_line.sv =====
// line buffer, length and overflow tracking, command match and lamp state
// depends on lcdled_pkg
module lcdled_line #(
  parameter int LINE_DEPTH = lcdled_pkg::LINE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_take,
  input  logic [lcdled_pkg::BYTE_W-1:0] in_byte,
  output lcdled_pkg::lcdled_req_t       req
);
  import lcdled_pkg::*;

  localparam int LEN_W = $clog2(LINE_DEPTH + 1);
  localparam int IDX_W = $clog2(LINE_DEPTH);

  logic [BYTE_W-1:0] buf_r [LINE_DEPTH];
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              ovf_r, ovf_nxt;
  logic [LAMP_W-1:0] lamp_r, lamp_nxt;

  logic is_eol;
  logic not_full;
  logic hit_left, hit_middle, hit_right, hit_off;
  logic [CODE_W-1:0] code;

  assign is_eol   = (in_byte == CH_CR) || (in_byte == CH_LF);
  assign not_full = len_r < LEN_W'(LINE_DEPTH);

  // compare the stored line against each command word
  always_comb begin
    hit_left   = (len_r == LEN_W'(4));
    hit_middle = (len_r == LEN_W'(6));
    hit_right  = (len_r == LEN_W'(5));
    hit_off    = (len_r == LEN_W'(3));
    for (int i = 0; i < 4; i++) begin
      hit_left = hit_left && (buf_r[i] == WORD_LEFT[8*(3-i) +: 8]);
    end
    for (int i = 0; i < 6; i++) begin
      hit_middle = hit_middle && (buf_r[i] == WORD_MIDDLE[8*(5-i) +: 8]);
    end
    for (int i = 0; i < 5; i++) begin
      hit_right = hit_right && (buf_r[i] == WORD_RIGHT[8*(4-i) +: 8]);
    end
    for (int i = 0; i < 3; i++) begin
      hit_off = hit_off && (buf_r[i] == WORD_OFF[8*(2-i) +: 8]);
    end
  end

  always_comb begin
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    lamp_nxt  = lamp_r;
    code      = RPL_ERR;
    req.start = 1'b0;
    if (!ovf_r) begin
      if (hit_left) begin
        code     = RPL_LEFT;
        lamp_nxt = LAMP_LEFT;
      end else if (hit_middle) begin
        code     = RPL_MIDDLE;
        lamp_nxt = LAMP_MIDDLE;
      end else if (hit_right) begin
        code     = RPL_RIGHT;
        lamp_nxt = LAMP_RIGHT;
      end else if (hit_off) begin
        code     = RPL_OFF;
        lamp_nxt = LAMP_NONE;
      end
    end
    if (!(in_take && is_eol && (len_r != '0 || ovf_r))) begin
      lamp_nxt = lamp_r;
    end
    if (in_take) begin
      if (!is_eol) begin
        if (not_full) begin
          len_nxt = len_r + LEN_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end else if (len_r != '0 || ovf_r) begin
        req.start = 1'b1;
        len_nxt   = '0;
        ovf_nxt   = 1'b0;
      end
    end
    req.code = code;
    req.lamp = lamp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      ovf_r  <= 1'b0;
      lamp_r <= LAMP_NONE;
    end else begin
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
      lamp_r <= lamp_nxt;
    end
  end

  // buffer entries hold no reset value; only entries below the length are compared
  always_ff @(posedge clk) begin
    if (in_take && !is_eol && not_full) begin
      buf_r[len_r[IDX_W-1:0]] <= in_byte;
    end
  end

endmodule

// ===== design/lcdled_reply.sv =====
// reply sequencer: walks the reply text and drives the registered result channel
// depends on lcdled_pkg
module lcdled_reply (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lcdled_pkg::lcdled_req_t       req,
  output logic                          idle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lcdled_pkg::BYTE_W-1:0] out_byte,
  output logic                          out_last,
  output logic [lcdled_pkg::LAMP_W-1:0] out_lamp
);
  import lcdled_pkg::*;

  logic                   act_r, act_nxt;
  logic [CODE_W-1:0]      code_r, code_nxt;
  logic [LAMP_W-1:0]      lamp_r, lamp_nxt;
  logic [REPLY_IDX_W-1:0] idx_r, idx_nxt;
  logic                   vld_r, vld_nxt;
  logic [BYTE_W-1:0]      byte_r, byte_nxt;
  logic                   last_r, last_nxt;
  logic [LAMP_W-1:0]      olamp_r, olamp_nxt;

  logic load;
  logic is_last;

  assign load    = act_r && (!vld_r || out_ready);
  assign is_last = (idx_r == reply_len(code_r) - REPLY_IDX_W'(1));

  always_comb begin
    act_nxt   = act_r;
    code_nxt  = code_r;
    lamp_nxt  = lamp_r;
    idx_nxt   = idx_r;
    vld_nxt   = vld_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    olamp_nxt = olamp_r;
    if (req.start) begin
      act_nxt  = 1'b1;
      code_nxt = req.code;
      lamp_nxt = req.lamp;
      idx_nxt  = '0;
    end
    if (load) begin
      vld_nxt   = 1'b1;
      byte_nxt  = reply_char(code_r, idx_r);
      last_nxt  = is_last;
      olamp_nxt = lamp_r;
      if (is_last) begin
        act_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + REPLY_IDX_W'(1);
      end
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      act_r <= act_nxt;
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r  <= code_nxt;
    lamp_r  <= lamp_nxt;
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
    olamp_r <= olamp_nxt;
  end

  assign idle      = !act_r;
  assign out_valid = vld_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;
  assign out_lamp  = olamp_r;

endmodule
